@@ design/assert_macros.svh @@
// Assertion helpers shared by the divider and datapath RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge while out of reset.
`define LCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds while out of reset.
`define LCM_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/lcm_pkg.sv @@
package lcm_pkg;

  // Datapath word and product widths
  localparam int DW     = 32;
  localparam int PW     = 2 * DW;
  localparam int CNT_W  = $clog2(DW);

  // Configuration space
  localparam int CFG_AW = 3;
  localparam logic       REG_LIMIT   = 1'b0;
  localparam logic [DW-1:0] LIMIT_RESET = 32'd1000000000;

  // Controller to datapath commands
  typedef struct packed {
    logic idle;       // ready for a new item
    logic mod_go;     // start b % a
    logic mod_take;   // a <= remainder, b <= a
    logic quo_go;     // start acc / g
    logic quo_take;   // capture quotient
    logic zero_prod;  // gcd is zero, product is zero
    logic mul;        // product <= quotient * period
    logic cmp;        // check product against limits
    logic push;       // load result register, start new set
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic accept;
    logic frozen;
    logic last;
    logic a_zero;
    logic b_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ design/lcm_in_if.sv @@
interface lcm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] period;
  logic        last;

  modport source (output valid, output period, output last, input ready);
  modport sink (input valid, input period, input last, output ready);
endinterface

@@ design/lcm_out_if.sv @@
interface lcm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] multiple;
  logic        over_limit;

  modport source (output valid, output multiple, output over_limit, input ready);
  modport sink (input valid, input multiple, input over_limit, output ready);
endinterface

@@ design/lcm_div.sv @@
`include "assert_macros.svh"

module lcm_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [lcm_pkg::DW-1:0] dividend,
  input  logic [lcm_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [lcm_pkg::DW-1:0] quotient,
  output logic [lcm_pkg::DW-1:0] remainder
);
  import lcm_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `LCM_ASSERT(a_div_nz, clk, rst_n, start |-> divisor != '0, "divide started with zero divisor")
  `LCM_NEVER(a_div_overlap, clk, rst_n, start && busy_r, "divide restarted while busy")
endmodule

@@ design/lcm_dp.sv @@
`include "assert_macros.svh"

module lcm_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  lcm_in_if.sink                 in_ch,
  lcm_out_if.source              out_ch,
  input  logic [lcm_pkg::DW-1:0] limit,
  input  lcm_pkg::ctrl_cmd_t     cmd,
  output lcm_pkg::dp_sts_t       sts
);
  import lcm_pkg::*;

  localparam logic [PW-1:0] VMASK = (PW'(1) << VALUE_BITS) - PW'(1);

  logic [VALUE_BITS-1:0] acc_r;
  logic                  flag_r;
  logic [DW-1:0]         a_r, b_r, p_r, q_r;
  logic                  last_r;
  logic [PW-1:0]         prod_r;
  logic                  out_valid_r;
  logic [DW-1:0]         mult_r;
  logic                  ovr_r;

  logic                  div_go;
  logic [DW-1:0]         div_dvd, div_dvs;
  logic                  div_done;
  logic [DW-1:0]         div_quo, div_rem;
  logic                  accept;
  logic                  too_big;

  assign accept = in_ch.valid && cmd.idle;
  assign in_ch.ready = cmd.idle;

  // Shared divider: Euclid modulo steps, then acc / gcd
  assign div_go  = cmd.mod_go || cmd.quo_go;
  assign div_dvd = cmd.quo_go ? DW'(acc_r) : b_r;
  assign div_dvs = cmd.quo_go ? b_r : a_r;

  lcm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign too_big = (prod_r > PW'(limit)) || (prod_r > VMASK);

  // Operand registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= DW'(acc_r);
      b_r    <= in_ch.period;
      p_r    <= in_ch.period;
      last_r <= in_ch.last;
    end else if (cmd.mod_take) begin
      a_r <= div_rem;
      b_r <= a_r;
    end
    if (cmd.quo_take) begin
      q_r <= div_quo;
    end
    if (cmd.zero_prod) begin
      prod_r <= '0;
    end else if (cmd.mul) begin
      prod_r <= PW'(q_r) * PW'(p_r);
    end
  end

  // Running multiple and over-limit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= VALUE_BITS'(1);
      flag_r <= 1'b0;
    end else if (cmd.push) begin
      acc_r  <= VALUE_BITS'(1);
      flag_r <= 1'b0;
    end else if (cmd.cmp) begin
      if (too_big) begin
        flag_r <= 1'b1;
      end else begin
        acc_r <= prod_r[VALUE_BITS-1:0];
      end
    end
  end

  // Result register; holds until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.push) begin
      mult_r <= flag_r ? '0 : DW'(acc_r);
      ovr_r  <= flag_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.multiple   = mult_r;
  assign out_ch.over_limit = ovr_r;

  assign sts.accept   = accept;
  assign sts.frozen   = flag_r;
  assign sts.last     = last_r;
  assign sts.a_zero   = (a_r == '0);
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  `LCM_ASSERT(a_frozen_acc, clk, rst_n, flag_r && !cmd.push |=> $stable(acc_r), "acc moved while frozen")
  `LCM_ASSERT(a_push_free, clk, rst_n, cmd.push |-> (!out_valid_r || out_ch.ready), "result overwritten")
  `LCM_ASSERT(a_ovr_zero, clk, rst_n, out_valid_r && ovr_r |-> mult_r == '0, "over-limit result nonzero")
endmodule

@@ design/lcm_ctrl.sv @@
module lcm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  lcm_pkg::dp_sts_t   sts,
  output lcm_pkg::ctrl_cmd_t cmd
);
  import lcm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_QST  = 3'd3;
  localparam logic [2:0] S_QUO  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      // Wait for an item; a frozen set skips the arithmetic
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.accept) begin
          state_nxt = sts.frozen ? S_FIN : S_GCD;
        end
      end
      // Euclid step: stop when the divisor reaches zero
      S_GCD: begin
        if (sts.a_zero) begin
          state_nxt = S_QST;
        end else begin
          cmd.mod_go = 1'b1;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.div_done) begin
          cmd.mod_take = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      // Divide the running multiple by the gcd
      S_QST: begin
        if (sts.b_zero) begin
          cmd.zero_prod = 1'b1;
          state_nxt     = S_CMP;
        end else begin
          cmd.quo_go = 1'b1;
          state_nxt  = S_QUO;
        end
      end
      S_QUO: begin
        if (sts.div_done) begin
          cmd.quo_take = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_FIN;
      end
      // Emit on the last item once the result register frees up
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

@@ design/running_lcm_saturating.sv @@
// Channel | Dir | Payload                       | Transfer when
// in_ch   | in  | period[31:0], last            | valid && ready
// out_ch  | out | multiple[31:0], over_limit    | valid && ready
// cfg_*   | in  | limit at byte address 0       | psel && penable && pwrite
//
// One item at a time; each Euclid modulo step and the final quotient run on one
// shared radix-2 divider. An item arriving after overflow skips the arithmetic.
// Reset is synchronous; it clears the running multiple to 1 and the flag.
// A stalled result holds in the output register; items without the last mark
// keep flowing, and a last item waits until that register frees up.
module running_lcm_saturating #(
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lcm_in_if.sink                     in_ch,
  lcm_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lcm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import lcm_pkg::*;

  logic [DW-1:0] limit_r;
  logic          reg_idx;
  ctrl_cmd_t     cmd;
  dp_sts_t       sts;

  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_LIMIT) ? limit_r : '0;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_idx == REG_LIMIT) begin
      limit_r <= cfg_pwdata;
    end
  end

  lcm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  lcm_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .limit  (limit_r),
    .cmd    (cmd),
    .sts    (sts)
  );
endmodule

@@ dv/tb_running_lcm_saturating.sv @@
`timescale 1ns / 100ps

module tb_running_lcm_saturating;

  localparam int VB = 32;
  localparam longint unsigned VALUE_MASK = 64'hFFFF_FFFF >> (32 - VB);
  localparam int REG_NONE = 1;  // index with no register behind it
  localparam int LIMIT_BYTE = 4 * int'(lcm_pkg::REG_LIMIT);
  localparam int NONE_BYTE  = 4 * REG_NONE;
  localparam logic [lcm_pkg::CFG_AW-1:0] LIMIT_ADDR = LIMIT_BYTE[lcm_pkg::CFG_AW-1:0];
  localparam logic [lcm_pkg::CFG_AW-1:0] NONE_ADDR  = NONE_BYTE[lcm_pkg::CFG_AW-1:0];
  localparam int SETTLE_CYCLES = 2000;   // worst Euclid item plus margin
  localparam int STUCK_LIMIT   = 20000;
  localparam int HOLD_AT       = 80;     // result count that starts the long hold-off
  localparam int HOLD_CYCLES   = 1500;
  localparam int RAND_PER_PHASE = 230;

  typedef struct packed {
    logic [31:0] period;
    logic        last;
  } lcm_item_t;

  typedef struct packed {
    logic [31:0] multiple;
    logic        over_limit;
  } lcm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lcm_in_if  in_bus();
  lcm_out_if out_bus();

  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [lcm_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0]                cfg_pwdata;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;

  running_lcm_saturating #(.VALUE_BITS(VB)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow state of the running multiple
  longint unsigned set_multiple = 1;
  bit              set_over     = 1'b0;
  logic [31:0]     limit_shadow = lcm_pkg::LIMIT_RESET;

  lcm_item_t   period_q[$];
  lcm_result_t pending_results[$];
  int          fails = 0;
  int          results_seen = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  lcm_item_t   next_item;
  lcm_result_t seen_exp;

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned a, b;
    a = x;
    b = y;
    while (a != 0) begin
      b = b % a;
      if (b == 0) return a;
      a = a % b;
    end
    return b;
  endfunction

  // Fold one period into the set; queue the result on the last mark
  function automatic void absorb_period(logic [31:0] p, logic lst);
    longint unsigned g, nxt;
    lcm_result_t r;
    if (!set_over) begin
      g = euclid(set_multiple & VALUE_MASK, {32'd0, p});
      if (g == 0) nxt = 0;
      else nxt = ((set_multiple & VALUE_MASK) / g) * {32'd0, p};
      if (nxt > {32'd0, limit_shadow} || nxt > VALUE_MASK) set_over = 1'b1;
      else set_multiple = nxt;
    end
    if (lst) begin
      r.multiple   = set_over ? 32'd0 : set_multiple[31:0];
      r.over_limit = set_over;
      pending_results.insert(pending_results.size(), r);
      set_multiple = 1;
      set_over     = 1'b0;
    end
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Input driver: offer queued items, idle a drawn number of cycles after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_period(in_bus.period, in_bus.last);
        in_gap = draw_gap(calm_in);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (period_q.size() != 0) begin
          next_item = period_q.pop_front();
          in_bus.period <= next_item.period;
          in_bus.last   <= next_item.last;
          in_bus.valid  <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation, then stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: multiple=%0d over_limit=%0b",
                 out_bus.multiple, out_bus.over_limit);
          fails++;
        end else begin
          seen_exp = pending_results.pop_front();
          if (out_bus.multiple !== seen_exp.multiple) begin
            $error("multiple: expected %0d, actual %0d", seen_exp.multiple, out_bus.multiple);
            fails++;
          end
          if (out_bus.over_limit !== seen_exp.over_limit) begin
            $error("over_limit: expected %0b, actual %0b",
                   seen_exp.over_limit, out_bus.over_limit);
            fails++;
          end
        end
        results_seen++;
        out_stall = draw_gap(calm_out);
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count busy cycles without any transfer
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        !(period_q.size() != 0 || in_bus.valid || pending_results.size() != 0))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("running_lcm_saturating verification failed");
      $finish;
    end
  end

  task automatic push_item(input logic [31:0] p, input logic lst);
    lcm_item_t it;
    it.period = p;
    it.last   = lst;
    period_q.insert(period_q.size(), it);
  endtask

  task automatic write_reg(input logic [lcm_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) limit_shadow = data;
  endtask

  task automatic check_limit_reg();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= LIMIT_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== limit_shadow) begin
      $error("limit: expected %0d, actual %0d", limit_shadow, cfg_prdata);
      fails++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Hold until every queued item is in and every result is out, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (period_q.size() != 0 || in_bus.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_period();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return $urandom_range(1, 24);
    else if (pick < 70) return $urandom_range(25, 2000);
    else if (pick < 78) return 32'd1 << $urandom_range(0, 31);
    else if (pick < 82) return 32'd0;
    else if (pick < 86) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    else return $urandom;
  endfunction

  // Mostly well-formed sets; some long runs without a last mark
  task automatic fill_random(input int target);
    int count, len, k;
    count = 0;
    while (count < target) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (k = 0; k < len; k++) push_item(rand_period(), (k == len - 1));
      count += len;
    end
  endtask

  task automatic random_phase(input logic [31:0] lim);
    write_reg(LIMIT_ADDR, lim);
    check_limit_reg();
    @(negedge clk);
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    fill_random(RAND_PER_PHASE);
    drain();
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.period  = 32'd0;
    in_bus.last    = 1'b0;
    out_bus.ready  = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = 32'd0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: basic sets, zero periods, limit edges, freeze after overflow
    check_limit_reg();
    @(negedge clk);
    push_item(32'd1, 1'b1);
    push_item(32'd0, 1'b1);
    push_item(32'd0, 1'b0);
    push_item(32'd0, 1'b0);
    push_item(32'd7, 1'b1);
    push_item(32'd4, 1'b0);
    push_item(32'd6, 1'b0);
    push_item(32'd10, 1'b1);
    push_item(32'd1000000000, 1'b1);
    push_item(32'd1000000001, 1'b1);
    push_item(32'd100000, 1'b0);
    push_item(32'd100003, 1'b0);
    push_item(32'd3, 1'b1);
    push_item(32'hFFFF_FFFF, 1'b1);
    drain();

    // Zero limit: only a zero multiple stays under it
    write_reg(LIMIT_ADDR, 32'd0);
    check_limit_reg();
    @(negedge clk);
    push_item(32'd0, 1'b1);
    push_item(32'd1, 1'b1);
    push_item(32'd0, 1'b0);
    push_item(32'd5, 1'b1);
    drain();

    // Full limit: deep Euclid chain, products past the word width
    write_reg(LIMIT_ADDR, 32'hFFFF_FFFF);
    check_limit_reg();
    @(negedge clk);
    push_item(32'd1836311903, 1'b0);
    push_item(32'd2971215073, 1'b1);
    push_item(32'd2971215073, 1'b1);
    push_item(32'd65536, 1'b0);
    push_item(32'd65537, 1'b1);
    push_item(32'd65535, 1'b0);
    push_item(32'd65537, 1'b1);
    drain();

    // Write to an unmapped index must leave the limit alone
    write_reg(NONE_ADDR, 32'd5);
    check_limit_reg();
    @(negedge clk);
    push_item(32'hFFFF_FFFF, 1'b1);
    drain();

    random_phase(32'd1);
    random_phase(lcm_pkg::LIMIT_RESET);
    random_phase($urandom_range(1000, 1000000));
    random_phase(32'hFFFF_FFFF);
    random_phase($urandom);
    random_phase($urandom_range(10, 500));

    if (fails == 0 && pending_results.size() == 0)
      $display("running_lcm_saturating verification clean");
    else
      $display("running_lcm_saturating verification failed");
    $finish;
  end

endmodule
